### src/shalloc_pkg.sv
// shared types, constants and codes of the subregion heap allocator
package shalloc_pkg;

  // field widths
  localparam int ADDR_W   = 32;
  localparam int REQ_W    = 16;
  localparam int BYTES_W  = 14;
  localparam int STATUS_W = 2;
  localparam int SUB_W    = 6;
  localparam int NSUB_W   = 4;

  // heap layout
  localparam int SUB_TOTAL    = 40;
  localparam int SMALL_COUNT  = 24;
  localparam int SMALL_SIZE   = 512;
  localparam int SMALL_SHIFT  = 9;
  localparam int LARGE_SHIFT  = 10;
  localparam int LARGE_OFFSET = 'h3000;
  localparam int REGION_SUBS  = 8;
  localparam int REGION_BITS  = $clog2(REGION_SUBS);
  localparam int MAX_REQUEST  = 8192;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 32'h2000_1000;

  // grant table sizing
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // beat packing
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  // opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic [SUB_W-1:0]  start;
    logic [NSUB_W-1:0] cnt;
  } grant_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACHK,
    ST_ASCAN,
    ST_ACOMMIT,
    ST_FREAD,
    ST_FCMP,
    ST_SHRD,
    ST_SHWR,
    ST_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic fail_nospace;
    logic fail_full;
    logic scan_step;
    logic commit;
    logic rd_en;
    logic cmp_hit;
    logic idx_inc;
    logic sh_wr;
    logic free_done;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_req;
    logic full;
    logic hit;
    logic scan_end;
    logic idx_in;
    logic match;
    logic out_free;
  } stat_t;

endpackage

### src/shalloc_ctrl.sv
// sequencing state machine of the subregion heap allocator
module shalloc_ctrl import shalloc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  input  logic  in_op,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_op == OP_FREE) ? ST_FREAD : ST_ACHK;
        end
      end
      ST_ACHK: begin
        if (stat.bad_req) begin
          cmd.fail_nospace = 1'b1;
          state_nxt        = ST_RESULT;
        end else if (stat.full) begin
          cmd.fail_full = 1'b1;
          state_nxt     = ST_RESULT;
        end else begin
          state_nxt = ST_ASCAN;
        end
      end
      ST_ASCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit) begin
          state_nxt = ST_ACOMMIT;
        end else if (stat.scan_end) begin
          cmd.fail_nospace = 1'b1;
          state_nxt        = ST_RESULT;
        end
      end
      ST_ACOMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_FREAD: begin
        if (stat.idx_in) begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_FCMP;
        end else begin
          cmd.fail_nospace = 1'b1;
          state_nxt        = ST_RESULT;
        end
      end
      ST_FCMP: begin
        if (stat.match) begin
          cmd.cmp_hit = 1'b1;
          state_nxt   = ST_SHRD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_FREAD;
        end
      end
      ST_SHRD: begin
        if (stat.idx_in) begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_SHWR;
        end else begin
          cmd.free_done = 1'b1;
          state_nxt     = ST_RESULT;
        end
      end
      ST_SHWR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = ST_SHRD;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### src/shalloc_dp.sv
// datapath: configuration register, used bitmap, grant table, walker, result and output registers
module shalloc_dp import shalloc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_wen,
  input  logic [ADDR_W-1:0]     cfg_wdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [STATUS_W-1:0]   out_tuser
);

  // start address of a subregion
  function automatic logic [ADDR_W-1:0] sub_addr(input logic [ADDR_W-1:0] base,
                                                 input logic [SUB_W-1:0]  g);
    logic [15:0] off;
    logic [SUB_W-1:0] lg;
    lg = g - SUB_W'(SMALL_COUNT);
    if (g < SUB_W'(SMALL_COUNT)) begin
      off = 16'(g) << SMALL_SHIFT;
    end else begin
      off = 16'(LARGE_OFFSET) + (16'(lg) << LARGE_SHIFT);
    end
    return base + ADDR_W'(off);
  endfunction

  logic [ADDR_W-1:0]   heap_base_r;
  logic [SUB_TOTAL-1:0] used_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    idx_r;
  logic [SUB_W-1:0]    g_r;
  logic [NSUB_W-1:0]   run_r;
  logic [NSUB_W-1:0]   n_r;
  logic                small_r;
  logic [REQ_W-1:0]    req_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [SUB_W-1:0]    start_r;
  logic [BYTES_W-1:0]  free_bytes_r;
  grant_t              tbl [TABLE_DEPTH];
  grant_t              rd_data_r;

  logic [STATUS_W-1:0] res_status_r;
  logic [ADDR_W-1:0]   res_addr_r;
  logic [BYTES_W-1:0]  res_bytes_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [BYTES_W-1:0]  out_bytes_r;

  logic [REQ_W-1:0]    in_req;
  logic [ADDR_W-1:0]   in_addr;
  logic [REQ_W:0]      in_round;
  logic                in_small;

  logic [NSUB_W-1:0]   run_eff;
  logic                cur_free;
  logic [SUB_W-1:0]    scan_start;
  logic [SUB_W-1:0]    mask_start;
  logic [NSUB_W-1:0]   mask_cnt;
  logic [SUB_W:0]      mask_end;
  logic [SUB_TOTAL-1:0] mask;
  logic [IDX_W-1:0]    wr_idx;
  logic [CNT_W-1:0]    idx_dec;
  logic [BYTES_W-1:0]  grant_bytes;

  // input beat fields
  assign in_req   = in_tdata[REQ_W-1:0];
  assign in_addr  = in_tdata[REQ_W+ADDR_W-1:REQ_W];
  assign in_round = {1'b0, in_req} + (REQ_W+1)'((1 << LARGE_SHIFT) - 1);
  assign in_small = (in_req <= REQ_W'(SMALL_SIZE));

  // walker step
  assign run_eff    = (g_r[REGION_BITS-1:0] == '0) ? '0 : run_r;
  assign cur_free   = ~used_r[g_r];
  assign scan_start = small_r ? g_r : (g_r + SUB_W'(1) - SUB_W'(n_r));

  // run mask for setting or clearing subregions
  assign mask_start = cmd.commit ? start_r : rd_data_r.start;
  assign mask_cnt   = cmd.commit ? n_r : rd_data_r.cnt;
  assign mask_end   = {1'b0, mask_start} + (SUB_W+1)'(mask_cnt);
  always_comb begin
    for (int g = 0; g < SUB_TOTAL; g++) begin
      mask[g] = ((SUB_W+1)'(g) >= {1'b0, mask_start}) && ((SUB_W+1)'(g) < mask_end);
    end
  end

  assign grant_bytes = small_r ? BYTES_W'(SMALL_SIZE) : (BYTES_W'(n_r) << LARGE_SHIFT);
  assign idx_dec     = idx_r - CNT_W'(1);
  assign wr_idx      = cmd.commit ? count_r[IDX_W-1:0] : idx_dec[IDX_W-1:0];

  // status to the controller
  always_comb begin
    stat.bad_req  = (req_r == '0) || (req_r > REQ_W'(MAX_REQUEST));
    stat.full     = (count_r >= CNT_W'(TABLE_DEPTH));
    stat.hit      = cur_free && (small_r || ((run_eff + NSUB_W'(1)) == n_r));
    stat.scan_end = small_r ? (g_r == SUB_W'(SMALL_COUNT - 1))
                            : (g_r == SUB_W'(SUB_TOTAL - 1));
    stat.idx_in   = (idx_r < count_r);
    stat.match    = (sub_addr(heap_base_r, rd_data_r.start) == addr_r);
    stat.out_free = !out_valid_r || out_tready;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= HEAP_BASE_RST;
    end else if (cfg_wen) begin
      heap_base_r <= cfg_wdata;
    end
  end

  // bitmap and table fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      count_r <= '0;
    end else begin
      if (cmd.commit) begin
        used_r  <= used_r | mask;
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.cmp_hit) begin
        used_r <= used_r & ~mask;
      end
      if (cmd.free_done) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // grant table memory
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tbl[wr_idx] <= '{start: start_r, cnt: n_r};
    end else if (cmd.sh_wr) begin
      tbl[wr_idx] <= rd_data_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= tbl[idx_r[IDX_W-1:0]];
    end
  end

  // operand capture and walker
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req;
      addr_r  <= in_addr;
      small_r <= in_small;
      n_r     <= in_small ? NSUB_W'(1) : in_round[LARGE_SHIFT+NSUB_W-1:LARGE_SHIFT];
      g_r     <= in_small ? '0 : SUB_W'(SMALL_COUNT);
      run_r   <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.scan_step) begin
        g_r     <= g_r + SUB_W'(1);
        run_r   <= cur_free ? (run_eff + NSUB_W'(1)) : '0;
        start_r <= scan_start;
      end
      if (cmd.idx_inc || cmd.cmp_hit || cmd.sh_wr) begin
        idx_r <= idx_r + CNT_W'(1);
      end
    end
    if (cmd.cmp_hit) begin
      free_bytes_r <= (rd_data_r.start < SUB_W'(SMALL_COUNT)) ? BYTES_W'(SMALL_SIZE)
                    : (BYTES_W'(rd_data_r.cnt) << LARGE_SHIFT);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.fail_nospace) begin
      res_status_r <= STATUS_NOSPACE;
      res_addr_r   <= '0;
      res_bytes_r  <= '0;
    end else if (cmd.fail_full) begin
      res_status_r <= STATUS_FULL;
      res_addr_r   <= '0;
      res_bytes_r  <= '0;
    end else if (cmd.commit) begin
      res_status_r <= STATUS_DONE;
      res_addr_r   <= sub_addr(heap_base_r, start_r);
      res_bytes_r  <= grant_bytes;
    end else if (cmd.free_done) begin
      res_status_r <= STATUS_DONE;
      res_addr_r   <= '0;
      res_bytes_r  <= free_bytes_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_bytes_r  <= res_bytes_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(OUT_DATA_W-ADDR_W-BYTES_W)'(0), out_bytes_r, out_addr_r};

endmodule

### src/subregion_heap_allocator.sv
// top level of the subregion heap allocator
//
//   channel  dir  handshake            payload
//   in       in   in_tvalid/in_tready  tuser: opcode; tdata: request_bytes, block_address
//   out      out  out_tvalid/out_tready tuser: status; tdata: granted_address, granted_bytes
//   cfg      in   cfg_wen              cfg_wdata: heap_base
//
// one request at a time; the next beat is taken the cycle after the result is loaded.
// allocate: the result waits on the one-bit-a-cycle walk over the used bitmap. free: the result
// waits on the single read port of the grant table (search, then each later entry is read
// and written back one slot lower).
// reset empties the bitmap and the table at once; no clearing pass.
// a stalled output holds the result and the block waits in its result state.
module subregion_heap_allocator import shalloc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // request_bytes [15:0], block_address [47:16]
  input  logic                  in_tuser,   // opcode [0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // granted_address [31:0], granted_bytes [45:32]
  output logic [STATUS_W-1:0]   out_tuser,  // status [1:0]
  input  logic                  cfg_wen,
  input  logic [ADDR_W-1:0]     cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  shalloc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  shalloc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
